// ----- hdl/gfn_pkg.sv -----
// ----------------------------------------------------------------------------
// gfn_pkg - shared types and constants for the grid face neighbor lookup
// widths follow from the axis limit; structs carry pipeline words
// ----------------------------------------------------------------------------
package gfn_pkg;

    // largest block count per axis
    localparam int AXIS_MAX = 64;

    // fixed field widths
    localparam int ID_W    = 18;
    localparam int OUT_W   = 19;
    localparam int CFG_W   = 7;
    localparam int ADDR_W  = 3;

    // derived widths
    localparam int CNT_W   = $clog2(AXIS_MAX + 1);
    localparam int PLANE_W = 2 * CNT_W;
    localparam int TOT_W   = 3 * CNT_W;
    localparam int WIDE_W  = ((TOT_W > ID_W) ? TOT_W : ID_W) + 1;
    localparam int Q_W     = 2 * CNT_W;
    localparam int STEPS   = 2 * CNT_W;

    // stream widths, whole bytes
    localparam int IN_TDATA_W  = ((ID_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((6 * OUT_W + 7) / 8) * 8;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_BLOCKS_X = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_BLOCKS_Y = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] REG_BLOCKS_Z = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] REG_PAD_X    = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] REG_PAD_Y    = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] REG_PAD_Z    = ADDR_W'(5);

    // configuration as seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]   nx;
        logic [CNT_W-1:0]   ny;
        logic [CNT_W-1:0]   nz;
        logic [CNT_W-1:0]   nx_m1;
        logic [PLANE_W-1:0] nxny;
        logic [PLANE_W-1:0] plane_less_row;
        logic [TOT_W-1:0]   total;
        logic [TOT_W-1:0]   tot_less_plane;
        logic               pad_x;
        logic               pad_y;
        logic               pad_z;
    } cfg_t;

    // word moving through the divider stages
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [WIDE_W-1:0]  rem;
        logic [PLANE_W-1:0] r1;
        logic [Q_W-1:0]     q;
    } div_word_t;

    // word between the two neighbor stages
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   x;
        logic [PLANE_W-1:0] yoff;
        logic [WIDE_W-1:0]  top;
        logic [WIDE_W-1:0]  bot;
        logic               yt;
        logic               yb;
        logic               xt;
        logic               xb;
        logic [5:0]         none;
        logic               bad;
    } nbr_word_t;

    // result word
    typedef struct packed {
        logic [OUT_W-1:0] left_id;
        logic [OUT_W-1:0] right_id;
        logic [OUT_W-1:0] front_id;
        logic [OUT_W-1:0] back_id;
        logic [OUT_W-1:0] bottom_id;
        logic [OUT_W-1:0] top_id;
        logic             bad_block;
    } result_t;

    // raw count to effective count: zero reads as one, clamp at the limit
    function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] raw);
        logic [CNT_W-1:0] res;
        if (raw == '0)
        begin
            res = CNT_W'(1);
        end
        else if (int'(raw) > AXIS_MAX)
        begin
            res = CNT_W'(AXIS_MAX);
        end
        else
        begin
            res = CNT_W'(raw);
        end
        return res;
    endfunction

endpackage

// ----- hdl/gfn_cfg.sv -----
// ----------------------------------------------------------------------------
// gfn_cfg - configuration registers and derived grid sizes
// plane and total sizes are registered products of the clamped counts
// ----------------------------------------------------------------------------
module gfn_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [gfn_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [gfn_pkg::CFG_W-1:0]  cfg_wdata,
    output gfn_pkg::cfg_t              cfg
);

    logic [gfn_pkg::CFG_W-1:0] blocks_x_reg;
    logic [gfn_pkg::CFG_W-1:0] blocks_y_reg;
    logic [gfn_pkg::CFG_W-1:0] blocks_z_reg;
    logic                      pad_x_reg;
    logic                      pad_y_reg;
    logic                      pad_z_reg;

    logic [gfn_pkg::CNT_W-1:0]   nx;
    logic [gfn_pkg::CNT_W-1:0]   ny;
    logic [gfn_pkg::CNT_W-1:0]   nz;
    logic [gfn_pkg::PLANE_W-1:0] nxny_reg;
    logic [gfn_pkg::PLANE_W-1:0] plane_less_row_reg;
    logic [gfn_pkg::TOT_W-1:0]   total_reg;
    logic [gfn_pkg::TOT_W-1:0]   tot_less_plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_x_reg <= gfn_pkg::CFG_W'(1);
            blocks_y_reg <= gfn_pkg::CFG_W'(1);
            blocks_z_reg <= gfn_pkg::CFG_W'(1);
            pad_x_reg    <= 1'b0;
            pad_y_reg    <= 1'b0;
            pad_z_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                gfn_pkg::REG_BLOCKS_X: blocks_x_reg <= cfg_wdata;
                gfn_pkg::REG_BLOCKS_Y: blocks_y_reg <= cfg_wdata;
                gfn_pkg::REG_BLOCKS_Z: blocks_z_reg <= cfg_wdata;
                gfn_pkg::REG_PAD_X:    pad_x_reg    <= cfg_wdata[0];
                gfn_pkg::REG_PAD_Y:    pad_y_reg    <= cfg_wdata[0];
                gfn_pkg::REG_PAD_Z:    pad_z_reg    <= cfg_wdata[0];
                default:               ;
            endcase
        end
    end

    assign nx = gfn_pkg::eff_count(blocks_x_reg);
    assign ny = gfn_pkg::eff_count(blocks_y_reg);
    assign nz = gfn_pkg::eff_count(blocks_z_reg);

    // first level: plane size, second level: totals
    always_ff @(posedge clk)
    begin
        nxny_reg           <= gfn_pkg::PLANE_W'(nx) * gfn_pkg::PLANE_W'(ny);
        plane_less_row_reg <= nxny_reg - gfn_pkg::PLANE_W'(nx);
        total_reg          <= gfn_pkg::TOT_W'(nxny_reg) * gfn_pkg::TOT_W'(nz);
        tot_less_plane_reg <= gfn_pkg::TOT_W'(nxny_reg)
                              * gfn_pkg::TOT_W'(nz - gfn_pkg::CNT_W'(1));
    end

    always_comb
    begin
        cfg.nx             = nx;
        cfg.ny             = ny;
        cfg.nz             = nz;
        cfg.nx_m1          = nx - gfn_pkg::CNT_W'(1);
        cfg.nxny           = nxny_reg;
        cfg.plane_less_row = plane_less_row_reg;
        cfg.total          = total_reg;
        cfg.tot_less_plane = tot_less_plane_reg;
        cfg.pad_x          = pad_x_reg;
        cfg.pad_y          = pad_y_reg;
        cfg.pad_z          = pad_z_reg;
    end

endmodule

// ----- hdl/gfn_div_step.sv -----
// ----------------------------------------------------------------------------
// gfn_div_step - one registered restoring division step
// compare and subtract the shifted divisor, shift the quotient bit in
// ----------------------------------------------------------------------------
module gfn_div_step
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gfn_pkg::div_word_t         in_data,
    input  logic [gfn_pkg::WIDE_W-1:0] divisor,
    output logic                       out_valid,
    input  logic                       out_ready,
    output gfn_pkg::div_word_t         out_data
);

    logic               valid_reg;
    gfn_pkg::div_word_t data_reg;
    gfn_pkg::div_word_t data_next;
    logic               fits;

    assign fits = (in_data.rem >= divisor);

    always_comb
    begin
        data_next = in_data;
        if (fits)
        begin
            data_next.rem = in_data.rem - divisor;
        end
        data_next.q = {in_data.q[gfn_pkg::Q_W-2:0], fits};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/gfn_nbr.sv -----
// ----------------------------------------------------------------------------
// gfn_nbr - neighbor numbers from coordinates, two register stages
// first stage: range check, edge tests, z neighbors; second: y and x
// ----------------------------------------------------------------------------
module gfn_nbr
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gfn_pkg::div_word_t in_data,
    input  gfn_pkg::cfg_t      cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output gfn_pkg::result_t   out_data
);

    localparam int W = gfn_pkg::WIDE_W;
    localparam int C = gfn_pkg::CNT_W;

    logic               a_valid_reg;
    gfn_pkg::nbr_word_t a_reg;
    gfn_pkg::nbr_word_t a_next;
    logic               a_ready;

    logic               b_valid_reg;
    gfn_pkg::result_t   b_reg;
    gfn_pkg::result_t   b_next;
    logic               b_ready;

    logic [C-1:0] x;
    logic [C-1:0] y;
    logic [C-1:0] z;
    logic [W-1:0] id_a;
    logic         bad;
    logic         zt;
    logic         zb;

    logic [W-1:0] id_b;
    logic [W-1:0] ybase;
    logic [W-1:0] xbase;
    logic [W-1:0] back_w;
    logic [W-1:0] front_w;
    logic [W-1:0] right_w;
    logic [W-1:0] left_w;

    // stage a
    assign x    = in_data.rem[C-1:0];
    assign y    = in_data.q[C-1:0];
    assign z    = in_data.q[gfn_pkg::Q_W-1:C];
    assign id_a = W'(in_data.id);
    assign bad  = (id_a >= W'(cfg.total));
    assign zt   = ({1'b0, z} + (C+1)'(1)) < {1'b0, cfg.nz};
    assign zb   = (z != '0);

    always_comb
    begin
        a_next.id   = in_data.id;
        a_next.x    = x;
        a_next.yoff = in_data.r1 - gfn_pkg::PLANE_W'(x);
        a_next.top  = zt ? id_a + W'(cfg.nxny) : W'(in_data.r1);
        a_next.bot  = zb ? id_a - W'(cfg.nxny)
                         : W'(in_data.r1) + W'(cfg.tot_less_plane);
        a_next.yt   = ({1'b0, y} + (C+1)'(1)) < {1'b0, cfg.ny};
        a_next.yb   = (y != '0);
        a_next.xt   = ({1'b0, x} + (C+1)'(1)) < {1'b0, cfg.nx};
        a_next.xb   = (x != '0);
        // none flags: top, bottom, back, front, right, left
        a_next.none[0] = bad || (!zt && cfg.pad_z);
        a_next.none[1] = bad || (!zb && cfg.pad_z);
        a_next.none[2] = bad || (!a_next.yt && cfg.pad_y);
        a_next.none[3] = bad || (!a_next.yb && cfg.pad_y);
        a_next.none[4] = bad || (!a_next.xt && cfg.pad_x);
        a_next.none[5] = bad || (!a_next.xb && cfg.pad_x);
        a_next.bad  = bad;
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_reg <= a_next;
        end
    end

    // stage b
    assign id_b    = W'(a_reg.id);
    assign ybase   = id_b - W'(a_reg.yoff);
    assign xbase   = id_b - W'(a_reg.x);
    assign back_w  = a_reg.yt ? id_b + W'(cfg.nx) : ybase;
    assign front_w = a_reg.yb ? id_b - W'(cfg.nx) : ybase + W'(cfg.plane_less_row);
    assign right_w = a_reg.xt ? id_b + W'(1) : xbase;
    assign left_w  = a_reg.xb ? id_b - W'(1) : xbase + W'(cfg.nx_m1);

    always_comb
    begin
        b_next.top_id    = a_reg.none[0] ? '1 : a_reg.top[gfn_pkg::OUT_W-1:0];
        b_next.bottom_id = a_reg.none[1] ? '1 : a_reg.bot[gfn_pkg::OUT_W-1:0];
        b_next.back_id   = a_reg.none[2] ? '1 : back_w[gfn_pkg::OUT_W-1:0];
        b_next.front_id  = a_reg.none[3] ? '1 : front_w[gfn_pkg::OUT_W-1:0];
        b_next.right_id  = a_reg.none[4] ? '1 : right_w[gfn_pkg::OUT_W-1:0];
        b_next.left_id   = a_reg.none[5] ? '1 : left_w[gfn_pkg::OUT_W-1:0];
        b_next.bad_block = a_reg.bad;
    end

    assign b_ready = !b_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

// ----- hdl/grid_face_neighbor_ids.sv -----
// ----------------------------------------------------------------------------
// grid_face_neighbor_ids - six face neighbors of a block in a 3d grid
// splits a linear block number into x, y, z and returns neighbor numbers
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    tdata: block_id
//  m_*       out  m_tvalid / m_tready    tdata: six neighbor ids, tuser: bad_block
//  cfg_*     in   cfg_we                 cfg_addr, cfg_wdata
//
//  one word per cycle sustained while m_tready stays high; stages: an input
//  register, one restoring division step per stage (z bits by plane size,
//  then y bits by row size) and two neighbor stages
//  reset clears all valid bits and loads the register defaults (1 block per
//  axis, all axes periodic); no clearing pass
//  each stage holds its word while the next one is full, so bubbles close up
//  and back-pressure only reaches s_tready once every stage is occupied
//  plane and total sizes are registered from the written counts, plane size first
//
module grid_face_neighbor_ids
(
    input  logic                            clk,
    input  logic                            rst_n,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gfn_pkg::IN_TDATA_W-1:0]  s_tdata,   // block_id

    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // top_id, bottom_id, back_id, front_id, right_id, left_id
    output logic [gfn_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]                      m_tuser,   // bad_block

    // configuration writes
    input  logic                            cfg_we,
    input  logic [gfn_pkg::ADDR_W-1:0]      cfg_addr,
    input  logic [gfn_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int STEPS  = gfn_pkg::STEPS;
    localparam int CNT_W  = gfn_pkg::CNT_W;
    localparam int WIDE_W = gfn_pkg::WIDE_W;
    localparam int DEPTH  = STEPS + 3;
    localparam int FL_W   = $clog2(DEPTH + 1);

    gfn_pkg::cfg_t      cfg;

    // stage k feeds division step k; stage STEPS feeds the neighbor unit
    gfn_pkg::div_word_t stg_data [0:STEPS];
    logic [STEPS:0]     stg_valid;
    logic [STEPS:0]     stg_ready;

    logic               in_valid_reg;
    gfn_pkg::div_word_t in_data_reg;
    gfn_pkg::div_word_t in_word;
    gfn_pkg::result_t   res;

    logic [FL_W-1:0]    inflight_reg;
    logic [FL_W-1:0]    inflight_next;

    gfn_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register in front of the first division step, giving the derived sizes time to settle
    always_comb
    begin
        in_word.id  = s_tdata[gfn_pkg::ID_W-1:0];
        in_word.rem = WIDE_W'(s_tdata[gfn_pkg::ID_W-1:0]);
        in_word.r1  = '0;
        in_word.q   = '0;
    end

    assign s_tready = !in_valid_reg || stg_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= in_word;
        end
    end

    assign stg_valid[0] = in_valid_reg;
    assign stg_data[0]  = in_data_reg;

    // division pipeline: first z = id / plane, then y = (id % plane) / row
    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            gfn_pkg::div_word_t    step_in;
            logic [WIDE_W-1:0]     step_div;

            if (k < CNT_W)
            begin : g_z
                assign step_div = WIDE_W'(cfg.nxny) << (CNT_W - 1 - k);
            end
            else
            begin : g_y
                assign step_div = WIDE_W'(cfg.nx) << (STEPS - 1 - k);
            end

            // remainder after the z steps is the in-plane offset
            always_comb
            begin
                step_in = stg_data[k];
                if (k == CNT_W)
                begin
                    step_in.r1 = stg_data[k].rem[gfn_pkg::PLANE_W-1:0];
                end
            end

            gfn_div_step u_step
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (stg_valid[k]),
                .in_ready  (stg_ready[k]),
                .in_data   (step_in),
                .divisor   (step_div),
                .out_valid (stg_valid[k+1]),
                .out_ready (stg_ready[k+1]),
                .out_data  (stg_data[k+1])
            );
        end
    endgenerate

    gfn_nbr u_nbr
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[STEPS]),
        .in_ready  (stg_ready[STEPS]),
        .in_data   (stg_data[STEPS]),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = gfn_pkg::OUT_TDATA_W'({res.left_id, res.right_id, res.front_id,
                                            res.back_id, res.bottom_id, res.top_id});
    assign m_tuser = res.bad_block;

    // words in flight, for checking only
    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_tvalid && s_tready)
        begin
            inflight_next = inflight_next + FL_W'(1);
        end
        if (m_tvalid && m_tready)
        begin
            inflight_next = inflight_next - FL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // an out-of-range block has no neighbors at all
    a_bad_all_none: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (&m_tdata[6*gfn_pkg::OUT_W-1:0]))
        else $error("bad block with a neighbor id");

    // input only stalls when the result is held back
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // pipeline never holds more words than it has stages
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= FL_W'(DEPTH))
        else $error("more words in flight than stages");

    // a result can only appear with a word in flight
    a_out_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (inflight_reg != '0))
        else $error("result without an accepted word");

endmodule

// ----- tb/tb_grid_face_neighbor_ids.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_face_neighbor_ids - self-checking bench for the face neighbor lookup
// block numbers go in through a queue-fed driver, a clocked monitor checks
// every result word against a local predictor; grid sizes and edge modes are
// rewritten between phases while the pipeline is empty
// ----------------------------------------------------------------------------
module tb_grid_face_neighbor_ids;

    localparam int CNT_W       = gfn_pkg::CNT_W;
    localparam int ID_W        = gfn_pkg::ID_W;
    localparam int OUT_W       = gfn_pkg::OUT_W;
    localparam int CFG_W       = gfn_pkg::CFG_W;
    localparam int ADDR_W      = gfn_pkg::ADDR_W;
    localparam int AXIS_MAX    = gfn_pkg::AXIS_MAX;
    localparam int IN_TDATA_W  = gfn_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = gfn_pkg::OUT_TDATA_W;

    // pipeline depth at 64 blocks per axis, used for idle pauses
    localparam int PIPE_DEPTH     = 2 * CNT_W + 3;
    localparam int MAX_ID         = (1 << ID_W) - 1;
    // no handshake for this many cycles means the block is stuck
    localparam int WATCHDOG_LIMIT = 2000;
    // long receiver hold-off, long enough to fill every stage
    localparam int HOLD_CYCLES    = 400;

    // indexes past the register map, writes there must do nothing
    localparam logic [ADDR_W-1:0] UNMAPPED_REG_A = ADDR_W'(6);
    localparam logic [ADDR_W-1:0] UNMAPPED_REG_B = ADDR_W'(7);

    // position of each neighbor inside the result word, lowest first
    typedef enum int
    {
        SLOT_TOP,
        SLOT_BOTTOM,
        SLOT_BACK,
        SLOT_FRONT,
        SLOT_RIGHT,
        SLOT_LEFT
    } nbr_slot_t;

    typedef struct packed {
        logic                       bad_block;
        logic [5:0][OUT_W-1:0]      ids;    // indexed by nbr_slot_t
    } nbr_result_t;

    string face_label [6] = '{"top_id", "bottom_id", "back_id",
                              "front_id", "right_id", "left_id"};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;

    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;     // block_id

    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // top_id, bottom_id, back_id, front_id, right_id, left_id
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]             m_tuser;            // bad_block

    logic                   cfg_we    = 1'b0;
    logic [ADDR_W-1:0]      cfg_addr  = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;

    // bench copy of the register file
    logic [CFG_W-1:0]       grid_x    = CFG_W'(1);
    logic [CFG_W-1:0]       grid_y    = CFG_W'(1);
    logic [CFG_W-1:0]       grid_z    = CFG_W'(1);
    logic                   edge_pad_x = 1'b0;
    logic                   edge_pad_y = 1'b0;
    logic                   edge_pad_z = 1'b0;

    logic [ID_W-1:0]        queued_ids [$];     // block numbers not yet offered
    nbr_result_t            expected_nbrs [$];  // predicted words, oldest first

    int                     send_gap_pct   = 0;
    int                     recv_gap_pct   = 0;
    logic                   hold_req       = 1'b0;
    int                     rx_hold_left   = 0;
    int                     mismatch_count = 0;
    int                     quiet_cycles   = 0;

    grid_face_neighbor_ids dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero counts as one block, anything past the limit is clamped
    function automatic int axis_len(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        return (int'(raw) > AXIS_MAX) ? AXIS_MAX : int'(raw);
    endfunction

    // one step along an axis of n blocks, -1 when a padded edge is crossed
    function automatic int step_axis(input int c, input int n, input logic pad,
                                     input logic up);
        if (up)
            return (c + 1 < n) ? c + 1 : (pad ? -1 : 0);
        return (c > 0) ? c - 1 : (pad ? -1 : n - 1);
    endfunction

    // linear number, x fastest, cut to the result field width
    function automatic logic [OUT_W-1:0] lin_id(input int x, input int y, input int z,
                                                input int nx, input int ny);
        return OUT_W'(x + y * nx + z * nx * ny);
    endfunction

    function automatic nbr_result_t face_neighbors(input logic [ID_W-1:0] id);
        int nx, ny, nz, x, y, z, t;
        nbr_result_t nb;
        nx = axis_len(grid_x);
        ny = axis_len(grid_y);
        nz = axis_len(grid_z);
        nb.ids       = '1;      // all faces start as no neighbor
        nb.bad_block = 1'b0;
        if (int'(id) >= nx * ny * nz)
        begin
            nb.bad_block = 1'b1;
        end
        else
        begin
            x = int'(id) % nx;
            y = (int'(id) / nx) % ny;
            z = int'(id) / (nx * ny);
            t = step_axis(z, nz, edge_pad_z, 1'b1);
            if (t >= 0) nb.ids[SLOT_TOP]    = lin_id(x, y, t, nx, ny);
            t = step_axis(z, nz, edge_pad_z, 1'b0);
            if (t >= 0) nb.ids[SLOT_BOTTOM] = lin_id(x, y, t, nx, ny);
            t = step_axis(y, ny, edge_pad_y, 1'b1);
            if (t >= 0) nb.ids[SLOT_BACK]   = lin_id(x, t, z, nx, ny);
            t = step_axis(y, ny, edge_pad_y, 1'b0);
            if (t >= 0) nb.ids[SLOT_FRONT]  = lin_id(x, t, z, nx, ny);
            t = step_axis(x, nx, edge_pad_x, 1'b1);
            if (t >= 0) nb.ids[SLOT_RIGHT]  = lin_id(t, y, z, nx, ny);
            t = step_axis(x, nx, edge_pad_x, 1'b0);
            if (t >= 0) nb.ids[SLOT_LEFT]   = lin_id(t, y, z, nx, ny);
        end
        return nb;
    endfunction

    // register copy follows the write port exactly, unknown indexes dropped
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x     <= CFG_W'(1);
            grid_y     <= CFG_W'(1);
            grid_z     <= CFG_W'(1);
            edge_pad_x <= 1'b0;
            edge_pad_y <= 1'b0;
            edge_pad_z <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gfn_pkg::REG_BLOCKS_X: grid_x     <= cfg_wdata;
                gfn_pkg::REG_BLOCKS_Y: grid_y     <= cfg_wdata;
                gfn_pkg::REG_BLOCKS_Z: grid_z     <= cfg_wdata;
                gfn_pkg::REG_PAD_X:    edge_pad_x <= cfg_wdata[0];
                gfn_pkg::REG_PAD_Y:    edge_pad_y <= cfg_wdata[0];
                gfn_pkg::REG_PAD_Z:    edge_pad_z <= cfg_wdata[0];
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly legal counts, now and then zero or past the clamp
    function automatic int rand_count();
        if ($urandom_range(5) == 0)
            return $urandom_range(127);
        return $urandom_range(AXIS_MAX, 1);
    endfunction

    // coordinate biased toward both edges of an axis
    function automatic int pick_edge_coord(input int n);
        case ($urandom_range(2))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(n - 1);
        endcase
    endfunction

    // block number drawn against the current grid
    function automatic logic [ID_W-1:0] pick_block_id();
        int nx, ny, nz, total;
        nx = axis_len(grid_x);
        ny = axis_len(grid_y);
        nz = axis_len(grid_z);
        total = nx * ny * nz;
        case ($urandom_range(9))
            // any 18-bit pattern
            0:       return ID_W'($urandom_range(MAX_ID));
            // past the grid total
            1:       return ID_W'((total <= MAX_ID) ? $urandom_range(MAX_ID, total)
                                                    : $urandom_range(MAX_ID));
            2, 3, 4: return ID_W'(pick_edge_coord(nx) + pick_edge_coord(ny) * nx
                                  + pick_edge_coord(nz) * nx * ny);
            default: return ID_W'($urandom_range(total - 1));
        endcase
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            queued_ids.push_back(pick_block_id());
    endtask

    task automatic set_gaps(input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
    endtask

    // sender stops until every predicted word has come back, then a pause
    task automatic wait_drained();
        do
            @(negedge clk);
        while (queued_ids.size() != 0 || s_tvalid || expected_nbrs.size() != 0);
        repeat (PIPE_DEPTH) @(negedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // new grid, written only with the pipeline empty; spare indexes get junk
    task automatic set_grid(input int bx, input int by, input int bz,
                            input logic px, input logic py, input logic pz);
        wait_drained();
        write_reg(gfn_pkg::REG_BLOCKS_X, bx);
        write_reg(gfn_pkg::REG_BLOCKS_Y, by);
        write_reg(gfn_pkg::REG_BLOCKS_Z, bz);
        write_reg(gfn_pkg::REG_PAD_X, px);
        write_reg(gfn_pkg::REG_PAD_Y, py);
        write_reg(gfn_pkg::REG_PAD_Z, pz);
        write_reg(UNMAPPED_REG_A, $urandom_range(127));
        write_reg(UNMAPPED_REG_B, $urandom_range(127));
        // pause so the registered derived sizes settle
        repeat (PIPE_DEPTH) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued block numbers, predicts on each accepted word
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_nbrs.push_back(face_neighbors(s_tdata[ID_W-1:0]));
            // a word on offer stays put until taken
            if (!s_tvalid || s_tready)
            begin
                if (queued_ids.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_TDATA_W'(queued_ids.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random ready, long hold-off on request, field-wise compare
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            rx_hold_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin : check_word
                nbr_result_t got, want;
                got.ids       = m_tdata[6*OUT_W-1:0];
                got.bad_block = m_tuser[0];
                if (expected_nbrs.size() == 0)
                begin
                    flag_mismatch($sformatf("word with nothing expected, top_id %0d",
                                            $signed(got.ids[SLOT_TOP])));
                end
                else
                begin
                    want = expected_nbrs.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (got.ids[k] !== want.ids[k])
                            flag_mismatch($sformatf("%s expected %0d got %0d",
                                face_label[k], $signed(want.ids[k]), $signed(got.ids[k])));
                    if (got.bad_block !== want.bad_block)
                        flag_mismatch($sformatf("bad_block expected %0b got %0b",
                                                want.bad_block, got.bad_block));
                end
            end

            // hold-off counted here so the sender keeps pushing meanwhile
            if (hold_req)
            begin
                rx_hold_left <= HOLD_CYCLES;
                m_tready     <= 1'b0;
            end
            else if (rx_hold_left != 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                m_tready     <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any handshake or register write
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // reset grid: one periodic block, so every face of block 0 is the block itself; 1 and MAX_ID lie past it
        static logic [ID_W-1:0] single_cases [3] = '{0, 1, MAX_ID};
        // 5x4x3, x and z padded: corners, each edge, last block, just past
        static logic [ID_W-1:0] box_cases [9] = '{0, 4, 19, 20, 33, 59, 60, 131072,
                                                  MAX_ID};
        // zero count, clamped count, single padded block on x and z
        static logic [ID_W-1:0] column_cases [4] = '{0, 30, 63, 64};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // sender idles lightly, receiver heavily
        set_gaps(10, 54);
        foreach (single_cases[i])
            queued_ids.push_back(single_cases[i]);

        set_grid(5, 4, 3, 1'b1, 1'b0, 1'b1);
        foreach (box_cases[i])
            queued_ids.push_back(box_cases[i]);
        queue_random(150);

        set_grid(0, 127, 1, 1'b1, 1'b1, 1'b1);
        foreach (column_cases[i])
            queued_ids.push_back(column_cases[i]);
        queue_random(150);

        // roles swapped
        set_grid(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b0, 1'b0, 1'b0);
        set_gaps(54, 10);
        queue_random(250);

        set_grid(1, 1, AXIS_MAX, 1'b0, 1'b1, 1'b0);
        queue_random(150);

        set_grid(rand_count(), rand_count(), rand_count(),
                 $urandom_range(1), $urandom_range(1), $urandom_range(1));
        queue_random(200);

        // back to back, no idling on either side
        set_grid(100, 65, 0, 1'b1, 1'b0, 1'b1);
        set_gaps(0, 0);
        queue_random(150);

        // full grid, all padded; receiver stalls so the pipe fills and
        // s_tready drops while the sender keeps offering
        set_grid(AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1, 1'b1, 1'b1);
        queue_random(250);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;

        repeat (3)
        begin
            set_grid(rand_count(), rand_count(), rand_count(),
                     $urandom_range(1), $urandom_range(1), $urandom_range(1));
            queue_random(150);
        end

        // drain, then wait on to catch stray words
        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gfn_pkg.sv
hdl/gfn_cfg.sv
hdl/gfn_div_step.sv
hdl/gfn_nbr.sv
hdl/grid_face_neighbor_ids.sv
tb/tb_grid_face_neighbor_ids.sv
